>>> sv/pstc_pkg.sv
package pstc_pkg;

   localparam int ERROR_WIDTH = 24;

   localparam int GAIN_W    = 16;
   localparam int DRIVE_W   = 16;
   localparam int UNIT_W    = 7;
   localparam int THRESH_W  = 23;
   localparam int TIME_W    = 32;
   localparam int INTEG_W   = 10;
   localparam int Q_SHIFT   = 8;
   localparam int INTEG_LIMIT = 256;

   // derived datapath widths
   localparam int PROD_W  = ERROR_WIDTH + GAIN_W;
   localparam int P_W     = PROD_W - Q_SHIFT;
   localparam int DIFF_W  = ERROR_WIDTH + 1;
   localparam int DPROD_W = DIFF_W + GAIN_W;
   localparam int D_W     = DPROD_W - Q_SHIFT;
   localparam int SUM_W   = D_W + 2;
   localparam int CMP_W   = ((ERROR_WIDTH > THRESH_W) ? ERROR_WIDTH : THRESH_W) + 2;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_KP               = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI               = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD               = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DRIVE        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DRIVE        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_THRESHOLD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_POWER     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_MS       = 3'd7;

   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [GAIN_W-1:0]   KP_RESET        = 16'd256;
   localparam logic [GAIN_W-1:0]   KI_RESET        = 16'd0;
   localparam logic [GAIN_W-1:0]   KD_RESET        = 16'd1280;
   localparam logic [UNIT_W-1:0]   MAX_DRIVE_RESET = 7'd127;
   localparam logic [UNIT_W-1:0]   MIN_DRIVE_RESET = 7'd0;
   localparam logic [THRESH_W-1:0] THRESH_RESET    = 23'd256;
   localparam logic [UNIT_W-1:0]   POWER_RESET     = 7'd5;
   localparam logic [TIME_W-1:0]   TIMEOUT_RESET   = 32'd3000;

   // action codes
   localparam logic ACT_START  = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   typedef struct packed {
      logic                   action;
      logic [ERROR_WIDTH-1:0] error;
      logic [TIME_W-1:0]      now_ms;
   } req_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] drive;
      logic               done_res;
      logic               timed_out;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   kp;
      logic [GAIN_W-1:0]   ki;
      logic [GAIN_W-1:0]   kd;
      logic [UNIT_W-1:0]   max_drive;
      logic [UNIT_W-1:0]   min_drive;
      logic [THRESH_W-1:0] settle_threshold;
      logic [UNIT_W-1:0]   settle_power;
      logic [TIME_W-1:0]   timeout_ms;
   } cfg_type;

   // controller state, current or next
   typedef struct packed {
      logic [INTEG_W-1:0]     integ;
      logic [ERROR_WIDTH-1:0] prev_err;
      logic [TIME_W-1:0]      start_time;
   } state_type;

endpackage

>>> sv/pstc_csr.sv
module pstc_csr
   import pstc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_KP:               cfg_in.kp               = wr_data[GAIN_W-1:0];
            CSR_KI:               cfg_in.ki               = wr_data[GAIN_W-1:0];
            CSR_KD:               cfg_in.kd               = wr_data[GAIN_W-1:0];
            CSR_MAX_DRIVE:        cfg_in.max_drive        = wr_data[UNIT_W-1:0];
            CSR_MIN_DRIVE:        cfg_in.min_drive        = wr_data[UNIT_W-1:0];
            CSR_SETTLE_THRESHOLD: cfg_in.settle_threshold = wr_data[THRESH_W-1:0];
            CSR_SETTLE_POWER:     cfg_in.settle_power     = wr_data[UNIT_W-1:0];
            CSR_TIMEOUT_MS:       cfg_in.timeout_ms       = wr_data[TIME_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp               <= KP_RESET;
         cfg_ff.ki               <= KI_RESET;
         cfg_ff.kd               <= KD_RESET;
         cfg_ff.max_drive        <= MAX_DRIVE_RESET;
         cfg_ff.min_drive        <= MIN_DRIVE_RESET;
         cfg_ff.settle_threshold <= THRESH_RESET;
         cfg_ff.settle_power     <= POWER_RESET;
         cfg_ff.timeout_ms       <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/pstc_calc.sv
module pstc_calc
   import pstc_pkg::*;
(
   input  req_type   item,
   input  cfg_type   cfg,
   input  state_type cur,
   output rsp_type   result,
   output state_type nxt
);

   logic signed [PROD_W-1:0]      p_prod;
   logic signed [PROD_W-1:0]      i_prod;
   logic signed [P_W-1:0]         p_term;
   logic signed [P_W-1:0]         i_term;
   logic signed [P_W:0]           i_sum;
   logic signed [INTEG_W-1:0]     i_clamp;
   logic signed [DIFF_W-1:0]      diff;
   logic signed [DPROD_W-1:0]     d_prod;
   logic signed [D_W-1:0]         d_term;
   logic signed [SUM_W-1:0]       total;
   logic signed [SUM_W-1:0]       limit;
   logic signed [DRIVE_W-1:0]     clamped;
   logic signed [DRIVE_W-1:0]     floor_v;
   logic signed [DRIVE_W-1:0]     drive;
   logic signed [DRIVE_W-1:0]     power_v;
   logic signed [CMP_W-1:0]       err_x;
   logic signed [CMP_W-1:0]       thr_x;
   logic        [TIME_W-1:0]      elapsed;
   logic                          settled;
   logic                          expired;
   logic                          done;

   // three independent products, each shifted down by the Q8.8 gain scale
   assign p_prod = $signed(cfg.kp) * $signed(item.error);
   assign i_prod = $signed(cfg.ki) * $signed(item.error);
   assign p_term = p_prod[PROD_W-1:Q_SHIFT];
   assign i_term = i_prod[PROD_W-1:Q_SHIFT];

   assign diff   = DIFF_W'($signed(item.error)) - DIFF_W'($signed(cur.prev_err));
   assign d_prod = $signed(cfg.kd) * diff;
   assign d_term = d_prod[DPROD_W-1:Q_SHIFT];

   assign i_sum = (P_W+1)'($signed(cur.integ)) + (P_W+1)'(i_term);

   always_comb begin
      if (i_sum > (P_W+1)'(INTEG_LIMIT)) begin
         i_clamp = INTEG_W'(INTEG_LIMIT);
      end else if (i_sum < -(P_W+1)'(INTEG_LIMIT)) begin
         i_clamp = -INTEG_W'(INTEG_LIMIT);
      end else begin
         i_clamp = i_sum[INTEG_W-1:0];
      end
   end

   assign total = SUM_W'(p_term) + SUM_W'(i_clamp) + SUM_W'(d_term);
   assign limit = SUM_W'({cfg.max_drive, {Q_SHIFT{1'b0}}});

   always_comb begin
      if (total > limit) begin
         clamped = limit[DRIVE_W-1:0];
      end else if (total < -limit) begin
         clamped = -limit[DRIVE_W-1:0];
      end else begin
         clamped = total[DRIVE_W-1:0];
      end
   end

   // raise a small positive drive to the floor, applied after the clamp
   assign floor_v = {1'b0, cfg.min_drive, {Q_SHIFT{1'b0}}};
   assign drive   = (clamped > 0 && clamped < floor_v) ? floor_v : clamped;

   assign err_x   = CMP_W'($signed(item.error));
   assign thr_x   = CMP_W'(cfg.settle_threshold);
   assign power_v = {1'b0, cfg.settle_power, {Q_SHIFT{1'b0}}};
   assign settled = (err_x < thr_x) && (err_x > -thr_x) && (drive <= power_v);

   assign elapsed = item.now_ms - cur.start_time;
   assign expired = elapsed >= cfg.timeout_ms;
   assign done    = settled || expired;

   always_comb begin
      if (item.action == ACT_START) begin
         result.drive     = '0;
         result.done_res  = 1'b0;
         result.timed_out = 1'b0;
         nxt.integ        = cur.integ;
         nxt.prev_err     = '0;
         nxt.start_time   = item.now_ms;
      end else begin
         result.drive     = drive;
         result.done_res  = done;
         result.timed_out = expired && !settled;
         nxt.integ        = i_clamp;
         nxt.prev_err     = done ? cur.prev_err : item.error;
         nxt.start_time   = cur.start_time;
      end
   end

endmodule

>>> sv/pid_settle_timeout_controller.sv
// PID drive controller with settle and timeout detection.
//
// Channels: req_* carries one transaction per start or sample (action, Q.8
// error, millisecond time stamp); rsp_* returns exactly one transaction per
// request (Q8.8 drive, done_res, timed_out) in request order. csr_* writes
// one of the eight gain/limit registers; csr_ready is always high, and
// registers should only be written while no transaction is in flight.
//
// Path: an accepted request is held in the request register, then moves
// to the response register and onto rsp_*. Throughput: one transaction per
// cycle while rsp_ready is high. The whole P/I/D computation sits in one
// combinational pass between the request and response registers, and
// the controller state (integral, previous error, start time) updates on
// the response capture edge, so the next request sees it without a bubble.
//
// Reset: synchronous, clears the valid flags, the integral, the previous
// error and the start time, and loads the register defaults.
// Stall: when rsp_ready is low the response holds; one more request can be
// captured in the request register, after which req_ready drops.
module pid_settle_timeout_controller
   import pstc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type   cfg;

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_data_ff;

   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_data_ff;

   state_type state_ff;
   state_type state_in;
   state_type calc_state;
   rsp_type   calc_rsp;

   logic      advance;
   logic      req_take;

   // register file always takes the write
   assign csr_ready = 1'b1;

   pstc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   pstc_calc u_calc (
      .item   (in_data_ff),
      .cfg    (cfg),
      .cur    (state_ff),
      .result (calc_rsp),
      .nxt    (calc_state)
   );

   // advance the held request when the response slot is empty or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);
   // commit state only as the transaction moves into the response register
   assign state_in     = advance ? calc_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers: request loads on take, response on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= calc_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
